// ===== sv/tlb_page_table_translator_assert.svh =====
// Assertion macros used by the translator's checker.
`ifndef TLB_PAGE_TABLE_TRANSLATOR_ASSERT_SVH
`define TLB_PAGE_TABLE_TRANSLATOR_ASSERT_SVH

// Same-cycle implication, sampled on clk and off while arst_n is low.
`define TLBPT_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("translator check failed");

// Next-cycle implication, sampled on clk and off while arst_n is low.
`define TLBPT_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("translator check failed");

`endif

// ===== sv/tlbpt_pkg.sv =====
// Shared types and constants of the page table translator.
`default_nettype none
package tlbpt_pkg;
	localparam int FRAME_W = 8;
	localparam int ADDR_W = 16;
	localparam int COUNT_W = 16;
	localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;

	// Update request from the sequencer to the TLB storage.
	typedef struct packed {
		logic upd;
		logic hit;
	} tlbpt_upd_t;
endpackage
`default_nettype wire

// ===== sv/tlb_page_table_translator.sv =====
// A taken item is compared with TLB entries from index zero up to the fill (the number of
// valid entries) and stops on a hit; the update writes the TLB, and on a fault the page
// table, and loads the result register once it is free. One item at a time, the next is
// taken only after the previous result is registered. Reset clears the page table at one
// entry per cycle (no item is taken before it ends), empties the TLB and zeroes counters.
`default_nettype none
module tlb_page_table_translator #(
	parameter int TLB_DEPTH = 16,
	parameter int PAGE_BITS = 8,
	parameter int OFFSET_BITS = 8
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic [tlbpt_pkg::ADDR_W-1:0]  virt_addr,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic      [tlbpt_pkg::FRAME_W-1:0] frame_number,
	output logic      [tlbpt_pkg::ADDR_W-1:0]  physical_address,
	output logic                               tlb_hit,
	output logic                               page_fault,
	output logic      [tlbpt_pkg::COUNT_W-1:0] hit_total,
	output logic      [tlbpt_pkg::COUNT_W-1:0] fault_total
);
	import tlbpt_pkg::*;

	localparam int IDX_W = (TLB_DEPTH > 1) ? $clog2(TLB_DEPTH) : 1;
	localparam int FILL_W = $clog2(TLB_DEPTH + 1);
	localparam int NF_W = PAGE_BITS + 1;
	localparam int NUM_PAGES = 1 << PAGE_BITS;
	localparam int RAM_DW = FRAME_W + 1;

	// Sequencer states.
	localparam logic [1:0] ST_CLEAR  = 2'd0;
	localparam logic [1:0] ST_IDLE   = 2'd1;
	localparam logic [1:0] ST_SCAN   = 2'd2;
	localparam logic [1:0] ST_UPDATE = 2'd3;

	logic [1:0]             state_q;
	logic [PAGE_BITS-1:0]   clr_idx_q;
	logic [FILL_W-1:0]      k_q;
	logic                   hit_q;
	logic [PAGE_BITS-1:0]   page_q;
	logic [OFFSET_BITS-1:0] offset_q;
	logic [NF_W-1:0]        next_free_q;
	logic [COUNT_W-1:0]     hit_cnt_q;
	logic [COUNT_W-1:0]     fault_cnt_q;

	logic                   out_valid_q;
	logic [FRAME_W-1:0]     frame_q;
	logic [ADDR_W-1:0]      phys_q;
	logic                   hit_out_q;
	logic                   fault_out_q;
	logic [COUNT_W-1:0]     hit_tot_q;
	logic [COUNT_W-1:0]     fault_tot_q;

	logic                   accept;
	logic                   out_free;
	logic                   go;
	logic [PAGE_BITS-1:0]   in_page;
	logic [FILL_W-1:0]      tlb_fill;
	logic [PAGE_BITS-1:0]   tlb_rd_page;
	logic [FRAME_W-1:0]     tlb_rd_frame;
	tlbpt_upd_t             tlb_ctrl;
	logic                   ram_we;
	logic [PAGE_BITS-1:0]   ram_waddr;
	logic [RAM_DW-1:0]      ram_wdata;
	logic [RAM_DW-1:0]      ram_rdata;
	logic                   ram_valid;
	logic                   fault;
	logic [FRAME_W-1:0]     nf_frame;
	logic [FRAME_W-1:0]     frame;
	logic [COUNT_W-1:0]     hit_cnt_next;
	logic [COUNT_W-1:0]     fault_cnt_next;

	// The block takes an item only in idle; once taken it stays busy until the
	// result is in the output register, which frees it while the result waits.
	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign go       = (state_q == ST_UPDATE) && out_free;
	assign in_page  = PAGE_BITS'(virt_addr >> OFFSET_BITS);

	// The page table word carries its own valid bit, cleared by the sweep.
	assign ram_valid = ram_rdata[FRAME_W];
	assign nf_frame  = FRAME_W'(next_free_q);
	assign fault     = !hit_q && !ram_valid;
	assign frame     = hit_q ? tlb_rd_frame : (ram_valid ? ram_rdata[FRAME_W-1:0] : nf_frame);

	assign hit_cnt_next = (hit_q && hit_cnt_q != COUNT_MAX) ?
		COUNT_W'(hit_cnt_q + 1'b1) : hit_cnt_q;
	assign fault_cnt_next = (fault && fault_cnt_q != COUNT_MAX) ?
		COUNT_W'(fault_cnt_q + 1'b1) : fault_cnt_q;

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = page_q;
		ram_wdata = {1'b1, nf_frame};
		if (state_q == ST_CLEAR) begin
			ram_we    = 1'b1;
			ram_waddr = clr_idx_q;
			ram_wdata = '0;
		end else if (go && fault) begin
			ram_we = 1'b1;
		end
	end

	assign tlb_ctrl.upd = go;
	assign tlb_ctrl.hit = hit_q;

	tlbpt_table_ram #(
		.AW(PAGE_BITS),
		.DW(RAM_DW)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (accept),
		.raddr (in_page),
		.rdata (ram_rdata)
	);

	tlbpt_tlb #(
		.DEPTH     (TLB_DEPTH),
		.PAGE_BITS (PAGE_BITS)
	) u_tlb (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (tlb_ctrl),
		.idx       (k_q[IDX_W-1:0]),
		.new_page  (page_q),
		.new_frame (frame),
		.fill      (tlb_fill),
		.rd_page   (tlb_rd_page),
		.rd_frame  (tlb_rd_frame)
	);

	// Sequencer: the scan compares one TLB entry per cycle against the page.
	// A hit leaves the index on the matching entry, so in the update cycle the
	// TLB read port still shows its frame and the index names the entry to move.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_idx_q   <= '0;
			k_q         <= '0;
			hit_q       <= 1'b0;
			next_free_q <= '0;
			hit_cnt_q   <= '0;
			fault_cnt_q <= '0;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					clr_idx_q <= PAGE_BITS'(clr_idx_q + 1'b1);
					if (clr_idx_q == PAGE_BITS'(NUM_PAGES - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						k_q     <= '0;
						hit_q   <= 1'b0;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (k_q == tlb_fill) begin
						state_q <= ST_UPDATE;
					end else if (tlb_rd_page == page_q) begin
						hit_q   <= 1'b1;
						state_q <= ST_UPDATE;
					end else begin
						k_q <= FILL_W'(k_q + 1'b1);
					end
				end
				ST_UPDATE: begin
					if (go) begin
						hit_cnt_q   <= hit_cnt_next;
						fault_cnt_q <= fault_cnt_next;
						if (fault && next_free_q != NF_W'(NUM_PAGES)) begin
							next_free_q <= NF_W'(next_free_q + 1'b1);
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			page_q   <= in_page;
			offset_q <= OFFSET_BITS'(virt_addr);
		end
	end

	// Output register: loaded at the end of the update cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (go) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			frame_q     <= frame;
			phys_q      <= ADDR_W'({frame, offset_q});
			hit_out_q   <= hit_q;
			fault_out_q <= fault;
			hit_tot_q   <= hit_cnt_next;
			fault_tot_q <= fault_cnt_next;
		end
	end

	assign out_valid        = out_valid_q;
	assign frame_number     = frame_q;
	assign physical_address = phys_q;
	assign tlb_hit          = hit_out_q;
	assign page_fault       = fault_out_q;
	assign hit_total        = hit_tot_q;
	assign fault_total      = fault_tot_q;
endmodule
`default_nettype wire

// ===== sv/tlbpt_table_ram.sv =====
// Page table memory with one write port and one registered read port.
`default_nettype none
module tlbpt_table_ram #(
	parameter int AW = 8,
	parameter int DW = 9
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [DW-1:0] wdata,
	input  wire logic          re,
	input  wire logic [AW-1:0] raddr,
	output logic      [DW-1:0] rdata
);
	logic [DW-1:0] mem [2**AW];
	logic [DW-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule
`default_nettype wire

// ===== sv/tlbpt_tlb.sv =====
// TLB entry storage kept in recency order, oldest entry at index zero.
`default_nettype none
module tlbpt_tlb #(
	parameter int DEPTH = 16,
	parameter int PAGE_BITS = 8,
	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int FILL_W = $clog2(DEPTH + 1)
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire tlbpt_pkg::tlbpt_upd_t         ctrl,
	input  wire logic [IDX_W-1:0]              idx,
	input  wire logic [PAGE_BITS-1:0]          new_page,
	input  wire logic [tlbpt_pkg::FRAME_W-1:0] new_frame,
	output logic      [FILL_W-1:0]             fill,
	output logic      [PAGE_BITS-1:0]          rd_page,
	output logic      [tlbpt_pkg::FRAME_W-1:0] rd_frame
);
	import tlbpt_pkg::*;

	logic [PAGE_BITS-1:0] page_q  [DEPTH];
	logic [FRAME_W-1:0]   frame_q [DEPTH];
	logic [FILL_W-1:0]    fill_q;
	logic                 full;
	logic                 rem;
	logic [IDX_W-1:0]     pos;
	logic [FILL_W-1:0]    newest;

	// A hit removes its own entry; a miss on a full TLB evicts the oldest.
	assign full   = (fill_q == FILL_W'(DEPTH));
	assign rem    = ctrl.hit || full;
	assign pos    = ctrl.hit ? idx : '0;
	assign newest = rem ? FILL_W'(fill_q - 1'b1) : fill_q;

	for (genvar i = 0; i < DEPTH; i++) begin : g_entry
		if (i < DEPTH - 1) begin : g_shift
			always_ff @(posedge clk) begin
				if (ctrl.upd) begin
					if (FILL_W'(i) == newest) begin
						page_q[i]  <= new_page;
						frame_q[i] <= new_frame;
					end else if (rem && (IDX_W'(i) >= pos) && (FILL_W'(i) < newest)) begin
						page_q[i]  <= page_q[i+1];
						frame_q[i] <= frame_q[i+1];
					end
				end
			end
		end else begin : g_last
			always_ff @(posedge clk) begin
				if (ctrl.upd && (FILL_W'(i) == newest)) begin
					page_q[i]  <= new_page;
					frame_q[i] <= new_frame;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (ctrl.upd && !rem) begin
			fill_q <= FILL_W'(fill_q + 1'b1);
		end
	end

	assign fill     = fill_q;
	assign rd_page  = page_q[idx];
	assign rd_frame = frame_q[idx];
endmodule
`default_nettype wire

// ===== sv/tlbpt_checker.sv =====
// Port-level checks of the translator and the bind that attaches them.
`default_nettype none
`include "tlb_page_table_translator_assert.svh"
module tlbpt_checker (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          in_valid,
	input wire logic                          in_stall,
	input wire logic                          out_valid,
	input wire logic                          out_stall,
	input wire logic [tlbpt_pkg::FRAME_W-1:0] frame_number,
	input wire logic [tlbpt_pkg::ADDR_W-1:0]  physical_address,
	input wire logic                          tlb_hit,
	input wire logic                          page_fault,
	input wire logic [tlbpt_pkg::COUNT_W-1:0] hit_total,
	input wire logic [tlbpt_pkg::COUNT_W-1:0] fault_total
);
	import tlbpt_pkg::*;

	logic [COUNT_W-1:0] last_hit_q;
	logic [COUNT_W-1:0] last_fault_q;
	logic               out_take;
	logic               in_take;

	assign out_take = out_valid && !out_stall;
	assign in_take  = in_valid && !in_stall;

	// Counter values of the last delivered item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_hit_q   <= '0;
			last_fault_q <= '0;
		end else if (out_take) begin
			last_hit_q   <= hit_total;
			last_fault_q <= fault_total;
		end
	end

	`TLBPT_ASSERT_NXT(a_out_hold, out_valid && out_stall,
		out_valid && $stable(physical_address) && $stable(frame_number))
	`TLBPT_ASSERT_NXT(a_busy_after_take, in_take, in_stall)
	`TLBPT_ASSERT_IMP(a_hit_no_fault, out_valid && tlb_hit, !page_fault)
	`TLBPT_ASSERT_IMP(a_hit_count, out_valid,
		(hit_total == (tlb_hit && last_hit_q != COUNT_MAX ?
			COUNT_W'(last_hit_q + 1'b1) : last_hit_q)))
	`TLBPT_ASSERT_IMP(a_fault_count, out_valid,
		(fault_total == (page_fault && last_fault_q != COUNT_MAX ?
			COUNT_W'(last_fault_q + 1'b1) : last_fault_q)))
endmodule

bind tlb_page_table_translator tlbpt_checker u_tlbpt_checker (.*);
`default_nettype wire

// ===== bench/tlb_page_table_translator_test.sv =====
// Self-checking bench for the TLB and demand-paged page table translator.
module tlb_page_table_translator_test;
	import tlbpt_pkg::*;

	// Geometry of the block as built with its default parameters.
	localparam int TLB_ENTRIES = 16;
	localparam int PAGE_W = 8;
	localparam int OFFSET_W = 8;
	localparam int PAGE_COUNT = 1 << PAGE_W;

	// Percentage of cycles in which either side holds back.
	localparam int IDLE_PCT = 16;
	localparam int RANDOM_ITEMS = 1728;
	// Wait after the last awaited result, longer than a miss with a full TLB takes.
	localparam int DRAIN_CYCLES = 40;

	// One translation as seen on the result channel.
	typedef struct packed {
		logic [FRAME_W-1:0] frame;
		logic [ADDR_W-1:0]  phys;
		logic               hit;
		logic               fault;
		logic [COUNT_W-1:0] hits;
		logic [COUNT_W-1:0] faults;
	} xlat_result_t;

	// A row of the directed table; the result is only used where typed is set.
	typedef struct packed {
		logic [ADDR_W-1:0] addr;
		logic              typed;
		xlat_result_t      want;
	} directed_row_t;

	localparam xlat_result_t NO_RESULT = '0;
	localparam int DIRECTED_ROWS = 22;

	// The first rows start from an empty TLB and page table, so the frames, flags and
	// totals follow by hand: pages take frames 0, 1, 2... in the order they first fault.
	// The rest fill the TLB to its depth, evict the oldest entry, bring the evicted page
	// back through the page table and hit an entry in the middle of the TLB.
	directed_row_t plan [DIRECTED_ROWS] = '{
		{16'h0000, 1'b1, 8'h00, 16'h0000, 1'b0, 1'b1, 16'd0, 16'd1},
		{16'h00FF, 1'b1, 8'h00, 16'h00FF, 1'b1, 1'b0, 16'd1, 16'd1},
		{16'hFFFF, 1'b1, 8'h01, 16'h01FF, 1'b0, 1'b1, 16'd1, 16'd2},
		{16'hFF00, 1'b1, 8'h01, 16'h0100, 1'b1, 1'b0, 16'd2, 16'd2},
		{16'h0180, 1'b1, 8'h02, 16'h0280, 1'b0, 1'b1, 16'd2, 16'd3},
		{16'h5555, 1'b1, 8'h03, 16'h0355, 1'b0, 1'b1, 16'd2, 16'd4},
		{16'hAAAA, 1'b1, 8'h04, 16'h04AA, 1'b0, 1'b1, 16'd2, 16'd5},
		{16'h1000, 1'b0, NO_RESULT},
		{16'h11FF, 1'b0, NO_RESULT},
		{16'h1201, 1'b0, NO_RESULT},
		{16'h1380, 1'b0, NO_RESULT},
		{16'h147F, 1'b0, NO_RESULT},
		{16'h1510, 1'b0, NO_RESULT},
		{16'h16EF, 1'b0, NO_RESULT},
		{16'h1702, 1'b0, NO_RESULT},
		{16'h18FD, 1'b0, NO_RESULT},
		{16'h1940, 1'b0, NO_RESULT},
		{16'h1AC3, 1'b0, NO_RESULT},
		{16'h2000, 1'b0, NO_RESULT},
		{16'h0042, 1'b0, NO_RESULT},
		{16'h1000, 1'b0, NO_RESULT},
		{16'hFF7F, 1'b0, NO_RESULT}
	};

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic [ADDR_W-1:0] virt_addr = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic [FRAME_W-1:0] frame_number;
	logic [ADDR_W-1:0]  physical_address;
	logic               tlb_hit;
	logic               page_fault;
	logic [COUNT_W-1:0] hit_total;
	logic [COUNT_W-1:0] fault_total;

	// While steady is set neither side idles, which gives a long back-to-back stretch.
	bit steady = 1'b0;
	int mismatch_count = 0;

	// Translations predicted for accepted items, oldest first.
	xlat_result_t awaited_results [$];

	// Shadow of the translator: the TLB as two queues with the oldest entry at the
	// front, the page table, the frame allocator and the two running totals.
	logic [PAGE_W-1:0]  tlb_pages [$];
	logic [FRAME_W-1:0] tlb_frames [$];
	logic [FRAME_W-1:0] page_frame [PAGE_COUNT];
	bit                 page_valid [PAGE_COUNT];
	logic [PAGE_W-1:0]  mapped_pages [$];
	logic [PAGE_W:0]    free_frame = '0;
	logic [COUNT_W-1:0] hits_seen = '0;
	logic [COUNT_W-1:0] faults_seen = '0;

	tlb_page_table_translator dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.virt_addr(virt_addr),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.frame_number(frame_number),
		.physical_address(physical_address),
		.tlb_hit(tlb_hit),
		.page_fault(page_fault),
		.hit_total(hit_total),
		.fault_total(fault_total)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Translates one address and updates the shadow state the way the block must.
	// A hit pulls the entry out of the TLB; either way the page then goes in as the
	// newest entry, pushing out the oldest one when the TLB is already full.
	function automatic xlat_result_t translate_address(input logic [ADDR_W-1:0] addr);
		xlat_result_t       res;
		logic [PAGE_W-1:0]  page;
		logic [FRAME_W-1:0] frame;
		bit                 found;
		int                 k;

		page = addr[OFFSET_W +: PAGE_W];
		found = 1'b0;
		frame = '0;
		k = 0;
		while (!found && k < tlb_pages.size()) begin
			if (tlb_pages[k] == page) begin
				found = 1'b1;
				frame = tlb_frames[k];
				tlb_pages.delete(k);
				tlb_frames.delete(k);
			end else begin
				k++;
			end
		end

		res.hit = found;
		res.fault = 1'b0;
		if (found) begin
			if (hits_seen != COUNT_MAX)
				hits_seen++;
		end else if (page_valid[page]) begin
			frame = page_frame[page];
		end else begin
			// Demand paging: the page gets the next frame in sequence. The allocator
			// stops at the page count, which is only reached once every page is mapped.
			res.fault = 1'b1;
			frame = free_frame[FRAME_W-1:0];
			page_frame[page] = frame;
			page_valid[page] = 1'b1;
			mapped_pages.push_back(page);
			if (free_frame < PAGE_COUNT)
				free_frame++;
			if (faults_seen != COUNT_MAX)
				faults_seen++;
		end

		if (tlb_pages.size() >= TLB_ENTRIES) begin
			void'(tlb_pages.pop_front());
			void'(tlb_frames.pop_front());
		end
		tlb_pages.push_back(page);
		tlb_frames.push_back(frame);

		res.frame = frame;
		res.phys = {frame, addr[OFFSET_W-1:0]};
		res.hits = hits_seen;
		res.faults = faults_seen;
		return res;
	endfunction

	// Offers one item, holding it steady while stalled. The item is taken at the edge
	// where valid is high and stall is low; its translation is then queued. Valid is
	// left high so that the next call can present a new item without a gap.
	task automatic send_item(input logic [ADDR_W-1:0] addr, input bit typed,
			input xlat_result_t want);
		xlat_result_t predicted;

		while (!steady && $urandom_range(99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		virt_addr <= addr;
		do
			@(posedge clk);
		while (in_stall);
		predicted = translate_address(addr);
		awaited_results.push_back(typed ? want : predicted);
	endtask

	task automatic check_field(input string label, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			mismatch_count++;
			$display("%0t: %s expected %0h, got %0h", $time, label, want, got);
		end
	endtask

	// Result side: the stall is redrawn every cycle, and every result taken is held
	// against the oldest translation still waiting.
	always @(posedge clk) begin
		xlat_result_t want;

		out_stall <= !steady && ($urandom_range(99) < IDLE_PCT);
		if (arst_n && out_valid && !out_stall) begin
			if (awaited_results.size() == 0) begin
				mismatch_count++;
				$display("%0t: expected no result, got frame %0h address %0h",
					$time, frame_number, physical_address);
			end else begin
				want = awaited_results.pop_front();
				check_field("frame_number", 32'(want.frame), 32'(frame_number));
				check_field("physical_address", 32'(want.phys), 32'(physical_address));
				check_field("tlb_hit", 32'(want.hit), 32'(tlb_hit));
				check_field("page_fault", 32'(want.fault), 32'(page_fault));
				check_field("hit_total", 32'(want.hits), 32'(hit_total));
				check_field("fault_total", 32'(want.faults), 32'(fault_total));
			end
		end
	end

	initial begin
		int                unsigned n;
		int                unsigned pick;
		logic [PAGE_W-1:0]   page_pick;
		logic [OFFSET_W-1:0] offset_pick;

		for (n = 0; n < PAGE_COUNT; n++)
			page_valid[n] = 1'b0;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// The block sweeps its page table after reset and stalls until that is done,
		// so the first item simply waits on the handshake.
		for (n = 0; n < DIRECTED_ROWS; n++)
			send_item(plan[n].addr, plan[n].typed, plan[n].want);

		// Random traffic. Most items reuse pages that sit in the TLB or are already
		// mapped, so hits, page table lookups and evictions all come up often; some
		// go for a page that was never mapped, so the frame sequence runs to its end.
		for (n = 0; n < RANDOM_ITEMS; n++) begin
			steady = (n >= 700 && n < 1000);
			pick = $urandom_range(99);
			page_pick = PAGE_W'($urandom_range(PAGE_COUNT - 1));
			offset_pick = OFFSET_W'($urandom_range((1 << OFFSET_W) - 1));
			if (pick < 35 && tlb_pages.size() != 0) begin
				page_pick = tlb_pages[$urandom_range(tlb_pages.size() - 1)];
			end else if (pick < 65 && mapped_pages.size() != 0) begin
				page_pick = mapped_pages[$urandom_range(mapped_pages.size() - 1)];
			end else if (pick < 75 && mapped_pages.size() < PAGE_COUNT) begin
				while (page_valid[page_pick])
					page_pick++;
			end
			send_item({page_pick, offset_pick}, 1'b0, NO_RESULT);
		end
		steady = 1'b0;
		in_valid <= 1'b0;

		while (awaited_results.size() != 0)
			@(posedge clk);
		// Any stray result in this window is caught by the result checker.
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatch_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	// Watchdog: several times the slowest correct run, in which every item misses a
	// full TLB and both sides hold back at random.
	initial begin
		#5000000;
		$display("Regression FAIL");
		$finish;
	end
endmodule
